/* src/suv_pkg.sv */
// Shared types and constants for the sorted unique values block.
`timescale 1ns / 1ps

package suv_pkg;

  // Number of cells in the insertion chain.
  localparam int MAX_ITEMS = 64;

  // Field widths.
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;

  // Input transaction payload.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               end_of_set;
  } in_item_t;

  // Output transaction payload.
  typedef struct packed {
    logic [VALUE_W-1:0] unique_value;
    logic               last_result;
    logic [COUNT_W-1:0] unique_count;
    logic               overflowed;
  } out_item_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

/* src/suv_cell.sv */
// One cell of the sorted insertion chain: holds a single value.
`timescale 1ns / 1ps

module suv_cell
  import suv_pkg::*;
(
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic               occupied,
  input  logic [VALUE_W-1:0] new_value,
  input  logic               left_less,
  input  logic [VALUE_W-1:0] left_value,
  input  logic [VALUE_W-1:0] right_value,
  output logic               less,
  output logic               equal,
  output logic [VALUE_W-1:0] value
);

  // Compare the held value against the value being inserted.
  assign less  = occupied && (value < new_value);
  assign equal = occupied && (value == new_value);

  // On insert, a cell keeps a smaller value, takes the new value at the
  // boundary, or takes its left neighbor's value to open the gap.
  // On shift, every value moves one cell toward the head of the chain.
  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (!less) begin
        value <= left_less ? new_value : left_value;
      end
    end else if (ctrl.shift) begin
      value <= right_value;
    end
  end

endmodule

/* src/sorted_unique_values.sv */
// Sorted unique values: an insertion chain that sorts and deduplicates a set.
// Throughput: one input transaction per cycle while a set is being loaded.
// Emission: once the final item is accepted, the held values are shifted out
// of the head cell into the output register, one result per cycle while the
// output is ready; input is held off until every held distinct value is emitted.
// Reset clears the count, the overflow flag, the control state and out_valid only.
`timescale 1ns / 1ps

module sorted_unique_values
  import suv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic               state;
  logic [COUNT_W-1:0] held_count;
  logic [COUNT_W-1:0] emit_count;
  logic               overflow_seen;

  logic [MAX_ITEMS-1:0] cell_less;
  logic [MAX_ITEMS-1:0] cell_equal;
  logic [MAX_ITEMS-1:0] cell_occupied;
  logic [VALUE_W-1:0]   cell_value [MAX_ITEMS];

  cell_ctrl_t ctrl;
  logic       in_fire;
  logic       is_dup;
  logic       is_full;
  logic       do_insert;
  logic       load_out;

  // Handshake and insert decision.
  assign in_ready  = (state == ST_LOAD);
  assign in_fire   = in_valid && in_ready;
  assign is_dup    = |cell_equal;
  assign is_full   = (held_count == COUNT_W'(MAX_ITEMS));
  assign do_insert = in_fire && !is_dup && !is_full;
  assign load_out  = (state == ST_EMIT) && (!out_valid || out_ready);

  assign ctrl.insert = do_insert;
  assign ctrl.shift  = load_out;

  // The chain of cells; a cell is occupied when its index is below the count.
  genvar i;
  generate
    for (i = 0; i < MAX_ITEMS; i++) begin : g_cell
      logic               left_less;
      logic [VALUE_W-1:0] left_value;
      logic [VALUE_W-1:0] right_value;

      assign cell_occupied[i] = (COUNT_W'(i) < held_count);

      if (i == 0) begin : g_head
        assign left_less  = 1'b1;
        assign left_value = in_item.value;
      end else begin : g_body
        assign left_less  = cell_less[i-1];
        assign left_value = cell_value[i-1];
      end

      if (i == MAX_ITEMS - 1) begin : g_tail
        assign right_value = cell_value[i];
      end else begin : g_inner
        assign right_value = cell_value[i+1];
      end

      suv_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occupied    (cell_occupied[i]),
        .new_value   (in_item.value),
        .left_less   (left_less),
        .left_value  (left_value),
        .right_value (right_value),
        .less        (cell_less[i]),
        .equal       (cell_equal[i]),
        .value       (cell_value[i])
      );
    end
  endgenerate

  // Control state: load phase, then emission of every held value.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      held_count    <= '0;
      emit_count    <= '0;
      overflow_seen <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (in_fire) begin
            if (do_insert) begin
              held_count <= held_count + COUNT_W'(1);
            end
            if (in_fire && !is_dup && is_full) begin
              overflow_seen <= 1'b1;
            end
            if (in_item.end_of_set) begin
              state      <= ST_EMIT;
              emit_count <= held_count + COUNT_W'(do_insert);
            end
          end
        end
        ST_EMIT: begin
          if (load_out) begin
            held_count <= held_count - COUNT_W'(1);
            if (held_count == COUNT_W'(1)) begin
              state         <= ST_LOAD;
              overflow_seen <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item.unique_value <= cell_value[0];
      out_item.last_result  <= (held_count == COUNT_W'(1));
      out_item.unique_count <= emit_count;
      out_item.overflowed   <= overflow_seen;
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the sorted unique values block.
`timescale 1ns / 1ps

module tb_top;
  import suv_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_SHOWN   = 30;
  localparam int PHASE_ITEMS = 6;
  localparam logic [VALUE_W-1:0] SCRAMBLE = 32'h9E37_79B9;

  // Block interface, every input known from time zero.
  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  sorted_unique_values uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  // Free-running clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Idling knobs, in percent, set per phase by the main sequence.
  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int holds_requested = 0;

  // Predictor state: the distinct values held so far, in ascending order.
  logic [VALUE_W-1:0] held_vals [MAX_ITEMS];
  int                 held_n       = 0;
  bit                 dropped_flag = 1'b0;
  out_item_t          step_results   [$];
  out_item_t          awaited_results[$];

  // Run statistics.
  int errors         = 0;
  int items_sent     = 0;
  int sets_done      = 0;
  int overflow_sets  = 0;
  int results_seen   = 0;
  int cycle_count    = 0;

  // Directed stimulus; typed rows carry the single result they must produce.
  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               end_of_set;
    bit                 typed;
    out_item_t          result;
  } dir_row_t;

  localparam int N_DIR = 22;
  dir_row_t dir_rows [N_DIR] = '{
    '{32'h0000_0000, 1'b1, 1'b1, '{32'h0000_0000, 1'b1, 7'd1, 1'b0}},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, '{32'hFFFF_FFFF, 1'b1, 7'd1, 1'b0}},
    '{32'h0000_0007, 1'b0, 1'b0, '0},
    '{32'h0000_0007, 1'b1, 1'b1, '{32'h0000_0007, 1'b1, 7'd1, 1'b0}},
    '{32'h0000_001E, 1'b0, 1'b0, '0},
    '{32'h0000_0014, 1'b0, 1'b0, '0},
    '{32'h0000_000A, 1'b0, 1'b0, '0},
    '{32'h0000_0014, 1'b0, 1'b0, '0},
    '{32'h0000_001E, 1'b1, 1'b0, '0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{32'h0000_0000, 1'b0, 1'b0, '0},
    '{32'h8000_0000, 1'b0, 1'b0, '0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, '0},
    '{32'h5555_5555, 1'b0, 1'b0, '0},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, '0},
    '{32'h0000_0000, 1'b0, 1'b0, '0},
    '{32'h0000_0001, 1'b1, 1'b0, '0},
    '{32'hDEAD_BEEF, 1'b0, 1'b0, '0},
    '{32'hDEAD_BEEF, 1'b0, 1'b0, '0},
    '{32'hDEAD_BEEF, 1'b1, 1'b1, '{32'hDEAD_BEEF, 1'b1, 7'd1, 1'b0}},
    '{32'h0000_0005, 1'b0, 1'b0, '0},
    '{32'h0000_0003, 1'b1, 1'b0, '0}
  };

  // Prints one mismatch line and counts it.
  task automatic report(string msg);
    errors++;
    if (errors <= MAX_SHOWN) begin
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
    end
  endtask

  // Inserts one value into the sorted set; on the final value, lists the set.
  function automatic void sort_dedup_step(in_item_t it);
    int        pos;
    int        k;
    bit        is_dup;
    out_item_t r;
    pos = 0;
    while (pos < held_n && held_vals[pos] < it.value) pos++;
    is_dup = (pos < held_n) && (held_vals[pos] == it.value);
    if (!is_dup) begin
      if (held_n >= MAX_ITEMS) begin
        dropped_flag = 1'b1;
      end else begin
        for (k = held_n; k > pos; k--) held_vals[k] = held_vals[k-1];
        held_vals[pos] = it.value;
        held_n++;
      end
    end
    if (it.end_of_set) begin
      for (k = 0; k < held_n; k++) begin
        r.unique_value = held_vals[k];
        r.last_result  = (k == held_n - 1);
        r.unique_count = COUNT_W'(held_n);
        r.overflowed   = dropped_flag;
        step_results.push_back(r);
      end
      sets_done++;
      if (dropped_flag) overflow_sets++;
      held_n       = 0;
      dropped_flag = 1'b0;
    end
  endfunction

  // Offers one transaction, waits for acceptance, then records what it must cause.
  task automatic send_value(logic [VALUE_W-1:0] v, logic eos, bit typed, out_item_t typed_res);
    in_item_t it;
    it.value      = v;
    it.end_of_set = eos;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    step_results.delete();
    sort_dedup_step(it);
    if (typed) begin
      awaited_results.push_back(typed_res);
    end else begin
      foreach (step_results[i]) awaited_results.push_back(step_results[i]);
    end
  endtask

  // Half full-range values, plus small values so that duplicates are common, and the extremes.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: return VALUE_W'($urandom_range(0, 7));
      default: return VALUE_W'($urandom());
    endcase
  endfunction

  task automatic send_random_set(int n);
    for (int i = 0; i < n; i++) send_value(pick_value(), (i == n - 1), 1'b0, '0);
  endtask

  // Fills the store with scrambled distinct values and a few repeats. Extra
  // distinct values beyond the capacity are dropped; the final value is
  // either new or a repeat of the first one.
  task automatic send_big_set(int n_distinct, int extra_distinct, bit final_new);
    logic [VALUE_W-1:0] salt;
    logic [VALUE_W-1:0] v;
    int                 total;
    salt  = VALUE_W'($urandom());
    total = n_distinct + extra_distinct;
    for (int i = 0; i < total; i++) begin
      v = (VALUE_W'(i) * SCRAMBLE) ^ salt;
      send_value(v, 1'b0, 1'b0, '0);
      if (i % 9 == 4) send_value(v, 1'b0, 1'b0, '0);
    end
    v = final_new ? ((VALUE_W'(total) * SCRAMBLE) ^ salt) : salt;
    send_value(v, 1'b1, 1'b0, '0);
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  int holds_served = 0;
  int hold_left    = 0;
  always @(posedge clk) begin
    if (hold_left == 0 && holds_served < holds_requested) begin
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES;
      out_ready    <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Compares every accepted output transaction with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        report($sformatf("unexpected result value %h", out_item.unique_value));
      end else begin
        want = awaited_results.pop_front();
        results_seen++;
        if (out_item.unique_value !== want.unique_value)
          report($sformatf("unique_value %h, expected %h",
                           out_item.unique_value, want.unique_value));
        if (out_item.last_result !== want.last_result)
          report($sformatf("last_result %b, expected %b on value %h",
                           out_item.last_result, want.last_result, want.unique_value));
        if (out_item.unique_count !== want.unique_count)
          report($sformatf("unique_count %0d, expected %0d on value %h",
                           out_item.unique_count, want.unique_count, want.unique_value));
        if (out_item.overflowed !== want.overflowed)
          report($sformatf("overflowed %b, expected %b on value %h",
                           out_item.overflowed, want.overflowed, want.unique_value));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, awaited_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Main sequence: reset, directed rows, idling phases, then the pressure phase.
  int phase_send [4] = '{0, 76, 0, 36};
  int phase_recv [4] = '{0, 0, 76, 36};
  initial begin
    int start_items;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed rows with the block free-running.
    foreach (dir_rows[i]) begin
      send_value(dir_rows[i].value, dir_rows[i].end_of_set, dir_rows[i].typed,
                 dir_rows[i].result);
    end

    // Short random sets under each idling mix.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      start_items    = items_sent;
      while (items_sent < start_items + PHASE_ITEMS) begin
        send_random_set(($urandom_range(0, 4) == 0) ? $urandom_range(6, 12)
                                                    : $urandom_range(1, 6));
      end
    end

    // The receiver holds off while the sender keeps offering, filling the block.
    // The full-store set then runs one distinct value past capacity.
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    holds_requested <= holds_requested + 1;
    start_items = items_sent;
    while (items_sent < start_items + 6) send_random_set($urandom_range(2, 4));
    send_big_set(MAX_ITEMS, 1, 1'b0);
    in_valid <= 1'b0;

    // Drain, then allow the emission latency to pass.
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d input transactions in %0d sets, %0d of them past capacity.",
             items_sent, sets_done, overflow_sets);
    $display("Checked %0d output transactions against predicted sorted sets.",
             results_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
